/* rtl/array_list_table_engine_defines.svh */
// Assertion macros shared by the list engine RTL.
// Define NO_ASSERTIONS to compile them away.
`ifndef ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH
`define ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A condition that holds at every clock edge outside reset.
`define ALTBL_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define ALTBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ALTBL_ASSERT(label, clk, rst_n, cond, msg)
`define ALTBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/altbl_pkg.sv */
package altbl_pkg;

  // Field widths of the request and result words.
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned POSITION_W = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned INDEX_W    = 7;
  localparam int unsigned COUNT_W    = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_SORTED = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CMP   = 2'd1,
    S_FIND  = 2'd2,
    S_APPLY = 2'd3
  } state_e;

  // How the row of cells moves.
  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_OPEN  = 2'd1,
    SH_CLOSE = 2'd2
  } shift_e;

  // Control word broadcast to every cell.
  typedef struct packed {
    shift_e                     op;
    action_e                    action;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

/* rtl/altbl_in_if.sv */
interface altbl_in_if import altbl_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic [ACTION_W-1:0]          action;
  logic signed [VALUE_W-1:0]    value;
  logic [POSITION_W-1:0]        position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);

endinterface

/* rtl/altbl_out_if.sv */
interface altbl_out_if import altbl_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [INDEX_W-1:0]    index;
  logic [COUNT_W-1:0]    entry_count;

  modport source (output valid, status, index, entry_count, input ready);
  modport sink   (input valid, status, index, entry_count, output ready);

endinterface

/* rtl/altbl_cell.sv */
module altbl_cell import altbl_pkg::*; #(
  parameter int unsigned IDX_W = 7,
  parameter int unsigned CNT_W = 8,
  parameter int unsigned INDEX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctl_t                  ctl_i,
  input  logic [IDX_W-1:0]           pivot_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic signed [VALUE_W-1:0]  left_i,
  input  logic signed [VALUE_W-1:0]  right_i,
  output logic signed [VALUE_W-1:0]  data_o,
  output logic                       hit_o
);

  logic signed [VALUE_W-1:0] data_q, data_d;
  logic                      hit_q, hit_d;
  logic                      in_use;
  logic                      above_pivot;
  logic                      at_pivot;

  assign in_use      = CNT_W'(INDEX) < count_i;
  assign above_pivot = IDX_W'(INDEX) > pivot_i;
  assign at_pivot    = IDX_W'(INDEX) == pivot_i;

  // Local compare on an entry in use: equality for a search, "not less" otherwise (used for a sorted insert).
  always_comb begin
    if (ctl_i.action == ACT_LOCATE) begin
      hit_d = in_use && (data_q == ctl_i.value);
    end else begin
      hit_d = in_use && !(data_q < ctl_i.value);
    end
  end

  // Shift the entry in from a neighbour, or take the new value at the pivot.
  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      SH_OPEN: begin
        if (above_pivot) begin
          data_d = left_i;
        end else if (at_pivot) begin
          data_d = ctl_i.value;
        end
      end
      SH_CLOSE: begin
        if (above_pivot || at_pivot) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

/* rtl/altbl_find.sv */
module altbl_find import altbl_pkg::*; #(
  parameter int unsigned N     = 128,
  parameter int unsigned IDX_W = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [N-1:0]      hits_i,
  output logic [IDX_W-1:0]  idx_o,
  output logic              any_o
);

  logic [N-1:0]     lowest;
  logic [IDX_W-1:0] idx_d, idx_q;
  logic             any_q;

  // Isolate the lowest set hit, then encode its position with an OR per index bit.
  assign lowest = hits_i & (~hits_i + N'(1));

  always_comb begin
    idx_d = '0;
    for (int unsigned i = 0; i < N; i++) begin
      if (lowest[i]) begin
        idx_d = idx_d | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else begin
      any_q <= |hits_i;
    end
  end

  assign idx_o = idx_q;
  assign any_o = any_q;

endmodule

/* rtl/array_list_table_engine.sv */
// Bounded list engine: a row of CAPACITY cells, each holding one signed 32-bit entry.
// Requests arrive on in_i (action, value, position), one word per operation, and
// each produces exactly one result word on out_o (status, index, entry_count).
// Both channels use a valid/ready handshake; a word moves when both are high.
// The result register is loaded in the S_APPLY state, after S_CMP and S_FIND; the
// steps are per-cell compare, first-hit search over the compare flags, then the
// shift of the whole row together with the result load.
// A new request is accepted once the engine is back in its idle state, in the cycle
// after the result load; no request is taken while an operation is in flight.
// The result sits in an output register; if the receiver holds ready low, the
// engine finishes the next operation up to its shift cycle and waits there,
// leaving the list unchanged until the held result has been taken.
// Reset clears the entry count and all handshake state; entry contents are not
// cleared and are never read before they have been written.
`include "array_list_table_engine_defines.svh"

module array_list_table_engine import altbl_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  altbl_in_if.sink    in_i,
  altbl_out_if.source out_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  state_e                     state_q, state_d;
  action_e                    act_q;
  logic signed [VALUE_W-1:0]  val_q;
  logic [POSITION_W-1:0]      pos_q;
  logic [CNT_W-1:0]           count_q, count_d;

  logic                       accept;
  logic                       go;
  logic                       in_ready;

  logic [CAPACITY-1:0]        hits;
  logic [IDX_W-1:0]           find_idx;
  logic                       find_any;

  status_e                    res_status;
  shift_e                     res_op;
  logic [IDX_W-1:0]           res_pivot;
  logic [CNT_W-1:0]           res_count;
  cell_ctl_t                  ctl;

  logic                       full;
  logic [CMP_W-1:0]           pos_ext;
  logic [CMP_W-1:0]           cnt_ext;

  logic                       out_valid_q, out_valid_d;
  status_e                    out_status_q;
  logic [INDEX_W-1:0]         out_index_q;
  logic [COUNT_W-1:0]         out_count_q;

  logic signed [VALUE_W-1:0]  cell_data [CAPACITY];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_CMP;
      S_CMP:   state_d = S_FIND;
      S_FIND:  state_d = S_APPLY;
      S_APPLY: if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and commit strobes.
  always_comb begin
    in_ready = (state_q == S_IDLE);
    go       = (state_q == S_APPLY) && (!out_valid_q || out_o.ready);
  end

  assign accept     = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Request word held for the whole operation.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_e'(in_i.action);
      val_q <= in_i.value;
      pos_q <= in_i.position;
    end
  end

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count_q);

  // Decide status, shift and pivot from the request and the search result.
  always_comb begin
    res_status = ST_DONE;
    res_op     = SH_NONE;
    res_pivot  = '0;
    res_count  = count_q;
    case (act_q)
      ACT_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          res_status = ST_RANGE;
        end else begin
          res_op    = SH_OPEN;
          res_pivot = IDX_W'(pos_q);
          res_count = count_q + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          res_status = ST_RANGE;
        end else begin
          res_op    = SH_CLOSE;
          res_pivot = IDX_W'(pos_q);
          res_count = count_q - CNT_W'(1);
        end
      end
      ACT_LOCATE: begin
        if (find_any) begin
          res_pivot = find_idx;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      ACT_SORTED: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_op    = SH_OPEN;
          res_pivot = find_any ? find_idx : IDX_W'(count_q);
          res_count = count_q + CNT_W'(1);
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  // Broadcast control: the row only moves in the commit cycle.
  always_comb begin
    ctl.op     = go ? res_op : SH_NONE;
    ctl.action = act_q;
    ctl.value  = val_q;
  end

  // Row of cells, each linked to its neighbours; an end cell takes itself for the missing one.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_w;
    logic signed [VALUE_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid
      assign left_w = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_inner
      assign right_w = cell_data[g+1];
    end

    altbl_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .pivot_i (res_pivot),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .hit_o   (hits[g])
    );
  end

  altbl_find #(
    .N     (CAPACITY),
    .IDX_W (IDX_W)
  ) u_find (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hits_i (hits),
    .idx_o  (find_idx),
    .any_o  (find_any)
  );

  // Entry count.
  assign count_d = go ? res_count : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register.
  assign out_valid_d = go ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_status_q <= res_status;
      out_index_q  <= (res_status == ST_DONE) ? INDEX_W'(res_pivot) : '0;
      out_count_q  <= COUNT_W'(res_count);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.index       = out_index_q;
  assign out_o.entry_count = out_count_q;

  // Checks on the engine's own control.
  `ALTBL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `ALTBL_ASSERT_IMP(a_count_commit, clk_i, rst_ni, !$stable(count_q), $past(go), "count changed outside a commit")
  `ALTBL_ASSERT_IMP(a_result_commit, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_APPLY), "result raised outside the commit state")
  `ALTBL_ASSERT_IMP(a_error_index, clk_i, rst_ni, out_valid_q && (out_status_q != ST_DONE), out_index_q == '0, "index not zero on an error status")

endmodule
